[sv/assert_macros.svh]
// Assertion shorthands; every use assumes clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition");

// Antecedent on one edge implies consequent on the next.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[sv/cotb_pkg.sv]
package cotb_pkg;

    // 64-bit offset header words at the head of a hybrid partition
    localparam int HDR_WORDS   = 4;
    localparam int CIP_W       = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] table_mode_t;
    localparam table_mode_t MODE_NONE   = 2'd0;
    localparam table_mode_t MODE_OFFSET = 2'd1;
    localparam table_mode_t MODE_HYBRID = 2'd2;

    typedef logic cfg_index_t;
    localparam cfg_index_t CFG_TABLE_MODE       = 1'b0;
    localparam cfg_index_t CFG_BLOCKS_PER_CHUNK = 1'b1;

    // Work handed from the front to the back for one accepted block
    typedef struct packed {
        logic             hdr_valid;
        logic [23:0]      hdr_index;
        logic [63:0]      hdr_value;
        logic             part_valid;
        logic [23:0]      part_index;
        logic [15:0]      part_value;
        logic [CIP_W-1:0] fill_count;
        logic [23:0]      fill_index;
    } cmd_t;

endpackage

[sv/cotb_front.sv]
module cotb_front
    import cotb_pkg::*;
#(
    parameter int CHUNKS_PER_PARTITION = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_accept,
    input  logic [15:0] block_length,
    input  logic        last_block,
    output logic        push,
    output cmd_t        cmd
);

    localparam int PART_WORDS = HDR_WORDS + CHUNKS_PER_PARTITION;

    table_mode_t      table_mode_reg;
    logic [15:0]      blocks_per_chunk_reg;
    logic [63:0]      running_offset_reg, running_offset_next;
    logic [15:0]      chunk_partial_reg, chunk_partial_next;
    logic [15:0]      blocks_in_chunk_reg, blocks_in_chunk_next;
    logic [23:0]      chunk_number_reg, chunk_number_next;
    logic [CIP_W-1:0] chunk_in_partition_reg, chunk_in_partition_next;
    logic [19:0]      partition_number_reg, partition_number_next;

    logic             mode_off, mode_hyb, active, done, part_wrap;
    logic [23:0]      part_base;
    logic [15:0]      partial_sum;
    logic [CIP_W-1:0] cip_inc;
    logic [63:0]      addend;

    always_comb
    begin
        mode_off    = (table_mode_reg == MODE_OFFSET);
        mode_hyb    = (table_mode_reg == MODE_HYBRID);
        active      = mode_off || mode_hyb;
        part_base   = {4'd0, partition_number_reg} * 24'(PART_WORDS);
        partial_sum = chunk_partial_reg + block_length;
        // a zero chunk size behaves like one
        done        = last_block ||
                      (({1'b0, blocks_in_chunk_reg} + 17'd1) >= {1'b0, blocks_per_chunk_reg});
        cip_inc     = chunk_in_partition_reg + {{(CIP_W-1){1'b0}}, 1'b1};
        part_wrap   = (cip_inc >= CIP_W'(CHUNKS_PER_PARTITION));

        chunk_in_partition_next = chunk_in_partition_reg;
        partition_number_next   = partition_number_reg;
        if (done)
        begin
            chunk_in_partition_next = part_wrap ? '0 : cip_inc;
            if (part_wrap)
                partition_number_next = partition_number_reg + 20'd1;
        end

        // offset mode sums every block, hybrid only the partials of completed chunks
        if (mode_off)
            addend = {48'd0, block_length};
        else if (done)
            addend = {48'd0, partial_sum};
        else
            addend = '0;
        running_offset_next  = running_offset_reg + addend;
        chunk_partial_next   = done ? 16'd0 : partial_sum;
        blocks_in_chunk_next = done ? 16'd0 : blocks_in_chunk_reg + 16'd1;
        chunk_number_next    = done ? chunk_number_reg + 24'd1 : chunk_number_reg;

        cmd.hdr_valid  = active && (blocks_in_chunk_reg == 16'd0) &&
                         (mode_off || (chunk_in_partition_reg == '0));
        cmd.hdr_index  = mode_off ? chunk_number_reg : part_base;
        cmd.hdr_value  = running_offset_reg;
        cmd.part_valid = mode_hyb && done;
        cmd.part_index = part_base + 24'(HDR_WORDS) + 24'(chunk_in_partition_reg);
        cmd.part_value = partial_sum;
        // no fill after a partition wrap, so part_base still holds
        cmd.fill_count = (mode_hyb && last_block && (chunk_in_partition_next != '0)) ?
                         CIP_W'(CHUNKS_PER_PARTITION) - chunk_in_partition_next : '0;
        cmd.fill_index = part_base + 24'(HDR_WORDS) + 24'(chunk_in_partition_next);

        push = in_accept && (cmd.hdr_valid || cmd.part_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_mode_reg         <= MODE_NONE;
            blocks_per_chunk_reg   <= 16'd1;
            running_offset_reg     <= '0;
            chunk_partial_reg      <= '0;
            blocks_in_chunk_reg    <= '0;
            chunk_number_reg       <= '0;
            chunk_in_partition_reg <= '0;
            partition_number_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TABLE_MODE:       table_mode_reg       <= cfg_data[1:0];
                    CFG_BLOCKS_PER_CHUNK: blocks_per_chunk_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (in_accept && active)
            begin
                if (last_block)
                begin
                    running_offset_reg     <= '0;
                    chunk_partial_reg      <= '0;
                    blocks_in_chunk_reg    <= '0;
                    chunk_number_reg       <= '0;
                    chunk_in_partition_reg <= '0;
                    partition_number_reg   <= '0;
                end
                else
                begin
                    running_offset_reg     <= running_offset_next;
                    chunk_partial_reg      <= chunk_partial_next;
                    blocks_in_chunk_reg    <= blocks_in_chunk_next;
                    chunk_number_reg       <= chunk_number_next;
                    chunk_in_partition_reg <= chunk_in_partition_next;
                    partition_number_reg   <= partition_number_next;
                end
            end
        end
    end

endmodule

[sv/cotb_fifo.sv]
module cotb_fifo
    import cotb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t pop_data,
    output logic full,
    output logic not_empty
);

    cmd_t               entries [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + {{(Q_PTR_W-1){1'b0}}, 1'b1};
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + {{(Q_PTR_W-1){1'b0}}, 1'b1};
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + {{(Q_CNT_W-1){1'b0}}, 1'b1};
                2'b01:   count_reg <= count_reg - {{(Q_CNT_W-1){1'b0}}, 1'b1};
                default: ;
            endcase
        end
    end

endmodule

[sv/cotb_back.sv]
module cotb_back
    import cotb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] entry_index,
    output logic [63:0] entry_value,
    output logic        entry_wide,
    output logic        last_result
);

    logic             hdr_pend_reg, part_pend_reg;
    logic [CIP_W-1:0] fill_left_reg;
    logic [23:0]      hdr_index_reg, part_index_reg, fill_index_reg;
    logic [63:0]      hdr_value_reg;
    logic [15:0]      part_value_reg;
    logic             out_valid_reg;
    logic [23:0]      entry_index_reg;
    logic [63:0]      entry_value_reg;
    logic             entry_wide_reg, last_result_reg;

    logic             busy, out_load, emit, more;
    logic [23:0]      sel_index;
    logic [63:0]      sel_value;
    logic             sel_wide;

    always_comb
    begin
        busy     = hdr_pend_reg || part_pend_reg || (fill_left_reg != '0);
        out_load = !out_valid_reg || !out_stall;
        emit     = out_load && busy;
        if (hdr_pend_reg)
        begin
            sel_index = hdr_index_reg;
            sel_value = hdr_value_reg;
            sel_wide  = 1'b1;
            more      = part_pend_reg || (fill_left_reg != '0);
        end
        else if (part_pend_reg)
        begin
            sel_index = part_index_reg;
            sel_value = {48'd0, part_value_reg};
            sel_wide  = 1'b0;
            more      = (fill_left_reg != '0);
        end
        else
        begin
            sel_index = fill_index_reg;
            sel_value = '0;
            sel_wide  = 1'b0;
            more      = (fill_left_reg > {{(CIP_W-1){1'b0}}, 1'b1});
        end
        // take the next command as the current one hands over its final result
        q_pop = q_valid && (!busy || (emit && !more));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pend_reg  <= 1'b0;
            part_pend_reg <= 1'b0;
            fill_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                hdr_pend_reg  <= q_cmd.hdr_valid;
                part_pend_reg <= q_cmd.part_valid;
                fill_left_reg <= q_cmd.fill_count;
            end
            else if (emit)
            begin
                if (hdr_pend_reg)
                    hdr_pend_reg <= 1'b0;
                else if (part_pend_reg)
                    part_pend_reg <= 1'b0;
                else
                    fill_left_reg <= fill_left_reg - {{(CIP_W-1){1'b0}}, 1'b1};
            end
            if (out_load)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hdr_index_reg  <= q_cmd.hdr_index;
            hdr_value_reg  <= q_cmd.hdr_value;
            part_index_reg <= q_cmd.part_index;
            part_value_reg <= q_cmd.part_value;
            fill_index_reg <= q_cmd.fill_index;
        end
        else if (emit && !hdr_pend_reg && !part_pend_reg)
            fill_index_reg <= fill_index_reg + 24'd1;
        if (emit)
        begin
            entry_index_reg <= sel_index;
            entry_value_reg <= sel_value;
            entry_wide_reg  <= sel_wide;
            last_result_reg <= !more;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = entry_index_reg;
    assign entry_value = entry_value_reg;
    assign entry_wide  = entry_wide_reg;
    assign last_result = last_result_reg;

endmodule

[sv/chunk_offset_table_builder.sv]
// Chunk offset table builder. Takes one block length per cycle (in_stall rises only
// when the four-deep command queue between the block counters and the result
// sequencer fills) and writes table entries at one per cycle while out_stall is low,
// from an output register that the first entry of an item reaches through the command
// queue and the sequencer's pending registers. An item gives between zero and
// CHUNKS_PER_PARTITION + 1 entries: a 64-bit offset at a chunk or partition start,
// a 16-bit chunk partial in hybrid mode, and on the last block the zero fill of the
// partition's unused slots. Input rate is one block per cycle while each block yields
// at most one entry and out_stall is low; otherwise the output port sets it.
// cfg_ready is always high; write configuration only while no entries are outstanding.
module chunk_offset_table_builder
    import cotb_pkg::*;
#(
    parameter int CHUNKS_PER_PARTITION = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] block_length,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] entry_index,
    output logic [63:0] entry_value,
    output logic        entry_wide,
    output logic        last_result
);

    logic push, q_full, q_valid, q_pop;
    cmd_t push_cmd, q_cmd;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    cotb_front #(
        .CHUNKS_PER_PARTITION(CHUNKS_PER_PARTITION)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (in_valid && !q_full),
        .block_length (block_length),
        .last_block   (last_block),
        .push         (push),
        .cmd          (push_cmd)
    );

    cotb_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .full      (q_full),
        .not_empty (q_valid)
    );

    cotb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .entry_wide  (entry_wide),
        .last_result (last_result)
    );

endmodule

[sv/cotb_checker.sv]
`include "assert_macros.svh"

module cotb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] entry_index,
    input logic [63:0] entry_value,
    input logic        entry_wide,
    input logic        last_result
);

    logic        out_xfer, narrow_more, zero_narrow, out_waiting;
    logic [23:0] next_index;
    logic [89:0] out_payload;

    assign out_xfer    = out_valid && !out_stall;
    assign narrow_more = out_xfer && !entry_wide && !last_result;
    assign zero_narrow = out_valid && !entry_wide && (entry_value == 64'd0);
    assign next_index  = entry_index + 24'd1;
    assign out_waiting = out_valid && out_stall;
    assign out_payload = {entry_index, entry_value, entry_wide, last_result};

    // narrow entries carry a 16-bit partial only
    `ASSERT_ALWAYS(a_narrow_value, !out_valid || entry_wide || (entry_value[63:16] == 48'd0))

    // a narrow entry that is not last is followed at once by a zero fill at the next word
    `ASSERT_NEXT(a_fill_follows, narrow_more, zero_narrow && (entry_index == $past(next_index)))

    `ASSERT_NEXT(a_hold_stalled, out_waiting, out_valid && $stable(out_payload))

    `ASSERT_ALWAYS(a_cfg_always_ready, cfg_ready)

endmodule

bind chunk_offset_table_builder cotb_checker u_cotb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .entry_wide   (entry_wide),
    .last_result  (last_result)
);
